[design/skt_pkg.sv]
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants of the sorted key table
// Operation and status codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int unsigned SKT_CAPACITY   = 64;
  localparam int unsigned SKT_NAME_BYTES = 8;

  localparam int unsigned SKT_FUNC_W    = 2;
  localparam int unsigned SKT_KEY_W     = 32;
  localparam int unsigned SKT_PAYLOAD_W = 64;
  localparam int unsigned SKT_STATUS_W  = 2;
  localparam int unsigned SKT_INDEX_W   = 6;
  localparam int unsigned SKT_COUNT_W   = 7;

  typedef enum logic [SKT_FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_SEARCH = 2'd1,
    FUNC_REMOVE = 2'd2
  } skt_func_e;

  typedef enum logic [SKT_STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_MISSING = 2'd3
  } skt_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_SRCH,
    S_CMP,
    S_SHIFT,
    S_DRAIN,
    S_PLACE
  } skt_state_e;

  typedef struct packed {
    logic        load;
    logic        srch_init;
    logic        rd_mid;
    logic        cmp;
    logic        shift_init;
    logic        shift_rd;
    logic        place;
    logic        dec;
    logic        respond;
    skt_status_e res_status;
  } skt_cmd_t;

  typedef struct packed {
    logic [SKT_FUNC_W-1:0] func;
    logic                  full;
    logic                  lo_lt_hi;
    logic                  found;
    logic                  lo_eq_count;
    logic                  lo_is_last;
    logic                  shift_last;
  } skt_stat_t;

endpackage

[design/skt_ram.sv]
// ----------------------------------------------------------------------------
// skt_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module skt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/skt_datapath.sv]
// ----------------------------------------------------------------------------
// skt_datapath: storage, search bounds and shift pointer of the key table
// Holds the key and payload memories, the record count, the binary search
// bounds, the shift pointer and the result registers.
// ----------------------------------------------------------------------------
module skt_datapath #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned NAME_BYTES = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  skt_pkg::skt_cmd_t                    cmd_i,
  output skt_pkg::skt_stat_t                   stat_o,
  input  logic [skt_pkg::SKT_FUNC_W-1:0]       func_i,
  input  logic signed [skt_pkg::SKT_KEY_W-1:0] key_i,
  input  logic [skt_pkg::SKT_PAYLOAD_W-1:0]    payload_i,
  output logic                                 done_o,
  output logic [skt_pkg::SKT_STATUS_W-1:0]     status_o,
  output logic [skt_pkg::SKT_INDEX_W-1:0]      index_o,
  output logic [skt_pkg::SKT_COUNT_W-1:0]      count_o
);

  import skt_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = NAME_BYTES * 8;

  logic [SKT_FUNC_W-1:0]       func_q;
  logic signed [SKT_KEY_W-1:0] key_q;
  logic [PW-1:0]               payload_q;
  logic [CW-1:0]               count_q;
  logic [CW-1:0]               lo_q;
  logic [CW-1:0]               hi_q;
  logic                        found_q;
  logic [AW-1:0]               ptr_q;
  logic [AW-1:0]               wr_addr_q;
  logic                        pend_q;
  logic [SKT_STATUS_W-1:0]     status_q;
  logic [SKT_INDEX_W-1:0]      index_q;
  logic                        done_q;

  logic [CW-1:0]               mid;
  logic [CW-1:0]               cnt_m1;
  logic [CW-1:0]               lo_p1;
  logic                        is_insert;
  logic [AW-1:0]               shift_end;
  logic [AW-1:0]               raddr;
  logic                        we;
  logic [AW-1:0]               waddr;
  logic [SKT_KEY_W-1:0]        wkey;
  logic [PW-1:0]               wpayload;
  logic [SKT_KEY_W-1:0]        rkey;
  logic [PW-1:0]               rpayload;

  assign mid       = lo_q + ((hi_q - lo_q) >> 1);
  assign cnt_m1    = count_q - 1'b1;
  assign lo_p1     = lo_q + 1'b1;
  assign is_insert = (func_q == FUNC_INSERT);
  assign shift_end = is_insert ? lo_q[AW-1:0] : cnt_m1[AW-1:0];
  assign raddr     = cmd_i.rd_mid ? mid[AW-1:0] : ptr_q;

  // A shifted entry is written back in the cycle after its read, from the RAM
  // output; the new record is written at its place once the shift is over.
  assign we       = pend_q | cmd_i.place;
  assign waddr    = pend_q ? wr_addr_q : lo_q[AW-1:0];
  assign wkey     = pend_q ? rkey : key_q;
  assign wpayload = pend_q ? rpayload : payload_q;

  skt_ram #(
    .WIDTH (SKT_KEY_W),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wkey),
    .raddr_i (raddr),
    .rdata_o (rkey)
  );

  skt_ram #(
    .WIDTH (PW),
    .DEPTH (CAPACITY)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wpayload),
    .raddr_i (raddr),
    .rdata_o (rpayload)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      if (cmd_i.place) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.dec) begin
        count_q <= cnt_m1;
      end
      pend_q <= cmd_i.shift_rd;
      done_q <= cmd_i.respond;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q    <= func_i;
      key_q     <= key_i;
      payload_q <= payload_i[PW-1:0];
    end
    if (cmd_i.srch_init) begin
      lo_q    <= '0;
      hi_q    <= count_q;
      found_q <= 1'b0;
    end else if (cmd_i.cmp) begin
      if ($signed(rkey) < key_q) begin
        lo_q <= mid + 1'b1;
      end else begin
        hi_q <= mid;
      end
      if ($signed(rkey) == key_q) begin
        found_q <= 1'b1;
      end
    end
    if (cmd_i.shift_init) begin
      ptr_q <= is_insert ? cnt_m1[AW-1:0] : lo_p1[AW-1:0];
    end else if (cmd_i.shift_rd) begin
      ptr_q     <= is_insert ? ptr_q - 1'b1 : ptr_q + 1'b1;
      wr_addr_q <= is_insert ? ptr_q + 1'b1 : ptr_q - 1'b1;
    end
    if (cmd_i.respond) begin
      status_q <= cmd_i.res_status;
      index_q  <= (cmd_i.res_status == ST_OK) ? SKT_INDEX_W'(lo_q) : '0;
    end
  end

  assign stat_o.func        = func_q;
  assign stat_o.full        = (count_q == CW'(CAPACITY));
  assign stat_o.lo_lt_hi    = (lo_q < hi_q);
  assign stat_o.found       = found_q;
  assign stat_o.lo_eq_count = (lo_q == count_q);
  assign stat_o.lo_is_last  = (lo_p1 == count_q);
  assign stat_o.shift_last  = (ptr_q == shift_end);

  assign done_o   = done_q;
  assign status_o = status_q;
  assign index_o  = index_q;
  assign count_o  = SKT_COUNT_W'(count_q);

endmodule

[design/skt_ctrl.sv]
// ----------------------------------------------------------------------------
// skt_ctrl: operation sequencer of the sorted key table
// Steps each operation through setup, binary search, entry shift and
// placement, and issues the result.
// ----------------------------------------------------------------------------
module skt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  skt_pkg::skt_stat_t stat_i,
  output skt_pkg::skt_cmd_t  cmd_o
);

  import skt_pkg::*;

  skt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_status = ST_MISSING;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_SETUP;
        end
      end
      S_SETUP: begin
        if (stat_i.func == FUNC_INSERT && stat_i.full) begin
          cmd_o.respond    = 1'b1;
          cmd_o.res_status = ST_FULL;
          state_d          = S_IDLE;
        end else if (stat_i.func == FUNC_INSERT || stat_i.func == FUNC_SEARCH ||
                     stat_i.func == FUNC_REMOVE) begin
          cmd_o.srch_init = 1'b1;
          state_d         = S_SRCH;
        end else begin
          cmd_o.respond = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_SRCH: begin
        if (stat_i.lo_lt_hi) begin
          cmd_o.rd_mid = 1'b1;
          state_d      = S_CMP;
        end else begin
          state_d = S_IDLE;
          case (stat_i.func)
            FUNC_INSERT: begin
              if (stat_i.found) begin
                cmd_o.respond    = 1'b1;
                cmd_o.res_status = ST_DUP;
              end else if (stat_i.lo_eq_count) begin
                state_d = S_PLACE;
              end else begin
                cmd_o.shift_init = 1'b1;
                state_d          = S_SHIFT;
              end
            end
            FUNC_SEARCH: begin
              cmd_o.respond    = 1'b1;
              cmd_o.res_status = stat_i.found ? ST_OK : ST_MISSING;
            end
            FUNC_REMOVE: begin
              if (!stat_i.found) begin
                cmd_o.respond = 1'b1;
              end else if (stat_i.lo_is_last) begin
                // The last record goes without any move.
                cmd_o.dec        = 1'b1;
                cmd_o.respond    = 1'b1;
                cmd_o.res_status = ST_OK;
              end else begin
                cmd_o.shift_init = 1'b1;
                state_d          = S_SHIFT;
              end
            end
            default: begin
              cmd_o.respond = 1'b1;
            end
          endcase
        end
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = S_SRCH;
      end
      S_SHIFT: begin
        cmd_o.shift_rd = 1'b1;
        if (stat_i.shift_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (stat_i.func == FUNC_INSERT) begin
          state_d = S_PLACE;
        end else begin
          cmd_o.dec        = 1'b1;
          cmd_o.respond    = 1'b1;
          cmd_o.res_status = ST_OK;
          state_d          = S_IDLE;
        end
      end
      S_PLACE: begin
        cmd_o.place      = 1'b1;
        cmd_o.respond    = 1'b1;
        cmd_o.res_status = ST_OK;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

[design/sorted_key_table_unit.sv]
// ----------------------------------------------------------------------------
// sorted_key_table_unit: ordered key table with binary search
// Keeps up to CAPACITY records sorted by signed key, with insert, search and
// remove operations.
// ----------------------------------------------------------------------------
// Usage:
//   An operation is taken when start is high and busy is low; func_i,
//   key_i and payload_i are sampled in that cycle. busy stays high until the
//   operation is finished, and done_o is then high for exactly one cycle, the
//   first cycle with busy low, with status_o, index_o and count_o; the
//   receiver cannot stall, so the result must be taken in that cycle. A new
//   operation may be started in the cycle in which done_o is shown.
//   Steps from the transfer to done_o: setup, then the binary search
//   probes (about log2(count+1) probes, one key memory read and compare
//   each), then for insert or remove the move of each record behind the
//   position, a drain step and, for insert, the placement. Refused
//   operations (full table, unused func) finish after setup. The record
//   move through the single read and write port of the memories sets the
//   worst case.
//   Reset empties the table at once; the memories need no clearing pass, as
//   entries at or above the count are never read.
// ----------------------------------------------------------------------------
module sorted_key_table_unit #(
  parameter int unsigned CAPACITY   = skt_pkg::SKT_CAPACITY,
  parameter int unsigned NAME_BYTES = skt_pkg::SKT_NAME_BYTES
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [skt_pkg::SKT_FUNC_W-1:0]       func_i,
  input  logic signed [skt_pkg::SKT_KEY_W-1:0] key_i,
  input  logic [skt_pkg::SKT_PAYLOAD_W-1:0]    payload_i,
  output logic                                 done_o,
  output logic [skt_pkg::SKT_STATUS_W-1:0]     status_o,
  output logic [skt_pkg::SKT_INDEX_W-1:0]      index_o,
  output logic [skt_pkg::SKT_COUNT_W-1:0]      count_o
);

  import skt_pkg::*;

  skt_cmd_t  cmd;
  skt_stat_t stat;

  skt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  skt_datapath #(
    .CAPACITY   (CAPACITY),
    .NAME_BYTES (NAME_BYTES)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .func_i    (func_i),
    .key_i     (key_i),
    .payload_i (payload_i),
    .done_o    (done_o),
    .status_o  (status_o),
    .index_o   (index_o),
    .count_o   (count_o)
  );

  // Every result follows an operation that was in progress.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result issued without an operation in progress");

  // A refused or failed operation reports index zero.
  a_fail_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (index_o == '0))
    else $error("non-zero index on a failed operation");

  // A full refusal leaves the count at capacity.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (count_o == SKT_COUNT_W'(CAPACITY)))
    else $error("table reported full below capacity");

  // The count only moves while an operation is in progress.
  a_count_stable_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !$past(busy)) |-> $stable(count_o))
    else $error("record count changed while idle");

endmodule

[verif/sorted_key_table_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_unit_tb: self-checking bench for the sorted key table
// A short table of directed operations is run first, covering the key
// extremes, every operation, refused inserts, missing keys and the unused
// selector. A fill to capacity follows, then random traffic in phases with
// different sender idling. Every result is checked against a pinned value
// or a model of the ordered table.
// ----------------------------------------------------------------------------
module sorted_key_table_unit_tb;
  import skt_pkg::*;

  localparam int unsigned CAP        = SKT_CAPACITY;
  localparam logic [SKT_FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [SKT_KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [SKT_KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;
  localparam logic [SKT_PAYLOAD_W-1:0] PAYLOAD_MASK = (SKT_NAME_BYTES >= 8) ? '1 :
      ((64'd1 << (8 * SKT_NAME_BYTES)) - 64'd1);
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 150;
  localparam int KEY_POOL_SIZE  = 128;
  localparam int PHASE_ITEMS    = 265;
  localparam int N_ROWS         = 20;

  typedef struct packed {
    skt_status_e             status;
    logic [SKT_INDEX_W-1:0]  index;
    logic [SKT_COUNT_W-1:0]  count;
  } table_reply_t;

  typedef struct packed {
    logic [SKT_FUNC_W-1:0]    func;
    logic [SKT_KEY_W-1:0]     key;
    logic [SKT_PAYLOAD_W-1:0] payload;
    logic                     pinned;
    skt_status_e              status;
    logic [SKT_INDEX_W-1:0]   index;
    logic [SKT_COUNT_W-1:0]   count;
  } step_row_t;

  // Rows with pinned set carry a result that can be read off directly; the
  // others are checked against the table model.
  localparam step_row_t DIRECTED_ROWS [0:N_ROWS-1] = '{
    '{FUNC_SEARCH, 32'd0,   64'd0,                 1'b1, ST_MISSING, 6'd0, 7'd0},
    '{FUNC_REMOVE, 32'd0,   64'hffff_ffff_ffff_ffff, 1'b1, ST_MISSING, 6'd0, 7'd0},
    '{FUNC_UNUSED, 32'd5,   64'hffff_ffff_ffff_ffff, 1'b1, ST_MISSING, 6'd0, 7'd0},
    '{FUNC_INSERT, KEY_MIN, 64'hffff_ffff_ffff_ffff, 1'b1, ST_OK,      6'd0, 7'd1},
    '{FUNC_INSERT, KEY_MAX, 64'd0,                 1'b1, ST_OK,      6'd1, 7'd2},
    '{FUNC_INSERT, 32'd0,   64'h0123_4567_89ab_cdef, 1'b1, ST_OK,      6'd1, 7'd3},
    '{FUNC_INSERT, 32'hffff_ffff, 64'ha5a5_a5a5_a5a5_a5a5, 1'b1, ST_OK, 6'd1, 7'd4},
    '{FUNC_INSERT, 32'd0,   64'h5555_5555_5555_5555, 1'b1, ST_DUP,     6'd0, 7'd4},
    '{FUNC_INSERT, KEY_MIN, 64'haaaa_aaaa_aaaa_aaaa, 1'b1, ST_DUP,     6'd0, 7'd4},
    '{FUNC_SEARCH, KEY_MAX, 64'd0,                 1'b1, ST_OK,      6'd3, 7'd4},
    '{FUNC_SEARCH, KEY_MIN, 64'd0,                 1'b1, ST_OK,      6'd0, 7'd4},
    '{FUNC_SEARCH, 32'd1,   64'd0,                 1'b1, ST_MISSING, 6'd0, 7'd4},
    '{FUNC_INSERT, 32'd12345, 64'h5a5a_5a5a_5a5a_5a5a, 1'b0, ST_OK,    6'd0, 7'd0},
    '{FUNC_INSERT, -32'sd12345, 64'hdead_beef_0000_ffff, 1'b0, ST_OK,  6'd0, 7'd0},
    '{FUNC_UNUSED, KEY_MAX, 64'd0,                 1'b1, ST_MISSING, 6'd0, 7'd6},
    '{FUNC_REMOVE, 32'hffff_ffff, 64'd0,           1'b0, ST_OK,      6'd0, 7'd0},
    '{FUNC_REMOVE, 32'hffff_ffff, 64'd0,           1'b1, ST_MISSING, 6'd0, 7'd5},
    '{FUNC_REMOVE, KEY_MAX, 64'd0,                 1'b0, ST_OK,      6'd0, 7'd0},
    '{FUNC_REMOVE, KEY_MIN, 64'd0,                 1'b1, ST_OK,      6'd0, 7'd3},
    '{FUNC_SEARCH, 32'd12345, 64'd0,               1'b0, ST_OK,      6'd0, 7'd0}
  };

  logic                            clk_i;
  logic                            rst_ni;
  logic                            op_start;
  logic                            op_busy;
  logic [SKT_FUNC_W-1:0]           op_func;
  logic signed [SKT_KEY_W-1:0]     op_key;
  logic [SKT_PAYLOAD_W-1:0]        op_payload;
  logic                            res_done;
  logic [SKT_STATUS_W-1:0]         res_status;
  logic [SKT_INDEX_W-1:0]          res_index;
  logic [SKT_COUNT_W-1:0]          res_count;

  // Model of the ordered table.
  logic signed [SKT_KEY_W-1:0]     held_keys [CAP];
  logic [SKT_PAYLOAD_W-1:0]        held_payloads [CAP];
  int                              n_held;

  table_reply_t                    pending_replies [$];
  table_reply_t                    pin_reply;
  logic                            pin_valid;
  logic signed [SKT_KEY_W-1:0]     key_pool [KEY_POOL_SIZE];
  int                              idle_pct;
  int                              err_count;
  int                              n_results;
  int                              quiet_cycles;
  bit                              filling;

  sorted_key_table_unit i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (op_start),
    .busy      (op_busy),
    .func_i    (op_func),
    .key_i     (op_key),
    .payload_i (op_payload),
    .done_o    (res_done),
    .status_o  (res_status),
    .index_o   (res_index),
    .count_o   (res_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic table_reply_t apply_op(logic [SKT_FUNC_W-1:0] f,
                                            logic signed [SKT_KEY_W-1:0] k,
                                            logic [SKT_PAYLOAD_W-1:0] p);
    table_reply_t r;
    int           pos;
    int           i;
    bit           hit;
    r.status = ST_MISSING;
    r.index  = '0;
    pos = 0;
    // First position whose key is not below k, in signed order.
    while (pos < n_held && held_keys[pos] < k) pos++;
    hit = (pos < n_held) && (held_keys[pos] == k);
    case (f)
      FUNC_INSERT: begin
        if (n_held >= CAP) begin
          r.status = ST_FULL;
        end else if (hit) begin
          r.status = ST_DUP;
        end else begin
          for (i = n_held; i > pos; i--) begin
            held_keys[i]     = held_keys[i-1];
            held_payloads[i] = held_payloads[i-1];
          end
          held_keys[pos]     = k;
          held_payloads[pos] = p & PAYLOAD_MASK;
          n_held++;
          r.status = ST_OK;
          r.index  = pos[SKT_INDEX_W-1:0];
        end
      end
      FUNC_SEARCH: begin
        if (hit) begin
          r.status = ST_OK;
          r.index  = pos[SKT_INDEX_W-1:0];
        end
      end
      FUNC_REMOVE: begin
        if (hit) begin
          for (i = pos; i + 1 < n_held; i++) begin
            held_keys[i]     = held_keys[i+1];
            held_payloads[i] = held_payloads[i+1];
          end
          n_held--;
          r.status = ST_OK;
          r.index  = pos[SKT_INDEX_W-1:0];
        end
      end
      default: ;
    endcase
    r.count = n_held[SKT_COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
    $display("MISMATCH result %0d %s: expected %0h, got %0h", n_results, field, want, got);
    err_count++;
  endtask

  // Result checking and prediction of every accepted transfer, in one place so
  // that a result and a new transfer at the same edge are handled in order.
  always @(posedge clk_i) begin
    table_reply_t want;
    table_reply_t predicted;
    if (rst_ni) begin
      if (res_done) begin
        if (pending_replies.size() == 0) begin
          report_mismatch("unexpected result", '0,
                          64'({res_status, res_index, res_count}));
        end else begin
          want = pending_replies.pop_front();
          if (res_status !== want.status) begin
            report_mismatch("status", 64'(want.status), 64'(res_status));
          end
          if (res_index !== want.index) begin
            report_mismatch("index", 64'(want.index), 64'(res_index));
          end
          if (res_count !== want.count) begin
            report_mismatch("count", 64'(want.count), 64'(res_count));
          end
        end
        n_results++;
      end
      if (op_start && !op_busy) begin
        predicted = apply_op(op_func, op_key, op_payload);
        pending_replies.push_back(pin_valid ? pin_reply : predicted);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((op_start && !op_busy) || res_done) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic drive_op(logic [SKT_FUNC_W-1:0] f, logic [SKT_KEY_W-1:0] k,
                          logic [SKT_PAYLOAD_W-1:0] p, logic pin,
                          table_reply_t pinned);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      op_start   <= 1'b0;
      op_func    <= SKT_FUNC_W'($urandom_range(0, 3));
      op_key     <= $urandom;
      op_payload <= {$urandom, $urandom};
      @(negedge clk_i);
    end
    pin_valid  = pin;
    pin_reply  = pinned;
    op_start   <= 1'b1;
    op_func    <= f;
    op_key     <= k;
    op_payload <= p;
    // The transfer happens at the first rising edge with busy low.
    forever begin
      @(posedge clk_i);
      if (!op_busy) break;
    end
  endtask

  task automatic wait_all_results(int extra);
    @(negedge clk_i);
    op_start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  function automatic logic [SKT_KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (n_held > 0 && roll < 45) return held_keys[$urandom_range(0, n_held - 1)];
    if (roll < 50) begin
      case ($urandom_range(0, 3))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    if (roll < 60) return $urandom;
    return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
  endfunction

  task automatic run_random(int n_items);
    int                    j;
    int                    roll;
    logic [SKT_FUNC_W-1:0] f;
    table_reply_t          none;
    none = '0;
    for (j = 0; j < KEY_POOL_SIZE; j++) key_pool[j] = $urandom;
    for (j = 0; j < n_items; j++) begin
      // Alternate between filling the table and draining it, so that both the
      // full and the empty ends are reached often.
      if (n_held == CAP && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (n_held == 0) filling = 1'b1;
      roll = $urandom_range(0, 99);
      if (filling) begin
        f = (roll < 65) ? FUNC_INSERT : (roll < 82) ? FUNC_SEARCH :
            (roll < 95) ? FUNC_REMOVE : FUNC_UNUSED;
      end else begin
        f = (roll < 55) ? FUNC_REMOVE : (roll < 75) ? FUNC_INSERT :
            (roll < 95) ? FUNC_SEARCH : FUNC_UNUSED;
      end
      drive_op(f, pick_key(), {$urandom, $urandom}, 1'b0, none);
    end
  endtask

  initial begin
    table_reply_t none;
    table_reply_t pinned;
    int           r;
    int           fill_key;
    none         = '0;
    n_held       = 0;
    err_count    = 0;
    n_results    = 0;
    quiet_cycles = 0;
    pin_valid    = 1'b0;
    pin_reply    = '0;
    filling      = 1'b1;
    idle_pct     = 0;
    rst_ni       = 1'b0;
    op_start     = 1'b0;
    op_func      = '0;
    op_key       = '0;
    op_payload   = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (r = 0; r < N_ROWS; r++) begin
      pinned.status = DIRECTED_ROWS[r].status;
      pinned.index  = DIRECTED_ROWS[r].index;
      pinned.count  = DIRECTED_ROWS[r].count;
      drive_op(DIRECTED_ROWS[r].func, DIRECTED_ROWS[r].key, DIRECTED_ROWS[r].payload,
               DIRECTED_ROWS[r].pinned, pinned);
    end

    // Fill to capacity with descending keys, so each insert moves most records.
    fill_key = 1000;
    while (n_held < CAP) begin
      wait_all_results(0);
      drive_op(FUNC_INSERT, fill_key, {$urandom, $urandom}, 1'b0, none);
      fill_key -= 7;
    end
    // Fullness is reported ahead of a duplicate key.
    drive_op(FUNC_INSERT, 32'd1, '1, 1'b1, '{ST_FULL, 6'd0, 7'd64});
    drive_op(FUNC_INSERT, 32'd0, '0, 1'b1, '{ST_FULL, 6'd0, 7'd64});
    drive_op(FUNC_SEARCH, -32'sd12345, '0, 1'b1, '{ST_OK, 6'd0, 7'd64});
    drive_op(FUNC_SEARCH, 32'd12345, '0, 1'b1, '{ST_OK, 6'd63, 7'd64});
    wait_all_results(0);

    idle_pct = 0;
    run_random(PHASE_ITEMS);
    wait_all_results(0);
    idle_pct = 81;
    run_random(PHASE_ITEMS);
    wait_all_results(0);
    idle_pct = 16;
    run_random(PHASE_ITEMS);
    wait_all_results(0);
    idle_pct = 81;
    run_random(PHASE_ITEMS);

    wait_all_results(TAIL_CYCLES);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
